// ===== rtl/fpsw_pkg.sv =====
// ---------------------------------------------------------------------------
// fpsw_pkg
// Shared types, register codes and helpers of the frame-pointer stack walker.
// ---------------------------------------------------------------------------
package fpsw_pkg;

    localparam int ADDR_W  = 64;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 64;

    localparam logic [ADDR_W-1:0] FRAME_SPAN = 64'd16;
    localparam logic [2:0]        ALIGN_MASK = 3'b111;

    typedef enum logic [1:0] {
        REG_STACK_BASE  = 2'd0,
        REG_STACK_TOP   = 2'd1,
        REG_STACK_KNOWN = 2'd2,
        REG_CAPACITY    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] stack_base;
        logic [ADDR_W-1:0] stack_top;
        logic              stack_known;
        logic [CNT_W-1:0]  capacity;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] current_frame;
        logic [ADDR_W-1:0] lower_bound;
        logic [ADDR_W-1:0] upper_limit;
        logic [CNT_W-1:0]  collected;
        logic              walking;
    } walk_state_t;

    typedef struct packed {
        logic              frame_valid;
        logic [ADDR_W-1:0] frame_addr;
        logic [IDX_W-1:0]  frame_index;
        logic              fetch_valid;
        logic [ADDR_W-1:0] fetch_addr;
        logic              done_res;
        logic [CNT_W-1:0]  total_frames;
    } result_t;

    function automatic logic is_canonical(input logic [ADDR_W-1:0] a);
        return (a[63:47] == '0) || (a[63:47] == '1);
    endfunction

    function automatic logic frame_ok(input logic [ADDR_W-1:0] f,
                                      input logic [ADDR_W-1:0] lo,
                                      input logic [ADDR_W-1:0] lim);
        return (f >= lo) && (f <= lim) && ((f[2:0] & ALIGN_MASK) == 3'b000);
    endfunction

endpackage

// ===== rtl/frame_pointer_stack_walker_core.sv =====
// ---------------------------------------------------------------------------
// frame_pointer_stack_walker_core
// An item is held in the input register, and its result in the result register.
// Throughput: one item per cycle while the result side is not stalled; input and result registers decouple stalls.
// A frame item that arrives while no walk runs is dropped without a result.
// Reset (rst_n low, asynchronous) clears walk state and valid flags;
// capacity resets to 64, the other registers to zero.
// ---------------------------------------------------------------------------
module frame_pointer_stack_walker_core
    import fpsw_pkg::*;
#(
    parameter int PAGE_BITS = 12,
    parameter int MAX_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    // start_ip, start_fp, start_sp, saved_link, saved_return
    input  logic [319:0]      s_tdata,
    // func
    input  logic [0:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // frame_addr, frame_index, fetch_addr, total_frames, zero pad
    output logic [143:0]      m_tdata,
    // frame_valid, fetch_valid
    output logic [1:0]        m_tuser,
    // done_res
    output logic              m_tlast
);

    cfg_t        cfg;
    walk_state_t state_reg;
    walk_state_t state_next;
    result_t     step_res;
    result_t     res_reg;
    logic        step_emit;
    logic        in_valid_reg;
    logic        in_func_reg;
    logic [319:0] in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;

    fpsw_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpsw_step #(
        .PAGE_BITS (PAGE_BITS),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_step (
        .cfg          (cfg),
        .state        (state_reg),
        .func         (in_func_reg),
        .start_ip     (in_data_reg[63:0]),
        .start_fp     (in_data_reg[127:64]),
        .start_sp     (in_data_reg[191:128]),
        .saved_link   (in_data_reg[255:192]),
        .saved_return (in_data_reg[319:256]),
        .emit         (step_emit),
        .result       (step_res),
        .state_next   (state_next)
    );

    assign advance  = in_valid_reg && (!step_emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && step_emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= s_tuser[0];
            in_data_reg <= s_tdata;
        end
        if (advance && step_emit)
            res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg.total_frames, res_reg.fetch_addr,
                       res_reg.frame_index, res_reg.frame_addr};
    assign m_tuser  = {res_reg.fetch_valid, res_reg.frame_valid};
    assign m_tlast  = res_reg.done_res;

    a_fetch_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1] ^ m_tlast))
        else $error("result must either request a fetch or end the walk");

    a_index_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ({1'b0, m_tdata[69:64]} < m_tdata[140:134]))
        else $error("frame index not below collected count");

    a_no_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while result side is ready");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.collected <= CNT_W'(MAX_DEPTH))
        else $error("collected count exceeds depth");

endmodule

// ===== rtl/fpsw_apb_regs.sv =====
// ---------------------------------------------------------------------------
// fpsw_apb_regs
// APB register file holding stack bounds, stack-known flag and capacity.
// ---------------------------------------------------------------------------
module fpsw_apb_regs
    import fpsw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_STACK_BASE:  cfg_next.stack_base  = pwdata;
                REG_STACK_TOP:   cfg_next.stack_top   = pwdata;
                REG_STACK_KNOWN: cfg_next.stack_known = pwdata[0];
                REG_CAPACITY:    cfg_next.capacity    = pwdata[CNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_STACK_BASE:  prdata = cfg_reg.stack_base;
            REG_STACK_TOP:   prdata = cfg_reg.stack_top;
            REG_STACK_KNOWN: prdata = {{(CFG_DW-1){1'b0}}, cfg_reg.stack_known};
            REG_CAPACITY:    prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg_reg.capacity};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stack_base  <= '0;
            cfg_reg.stack_top   <= '0;
            cfg_reg.stack_known <= 1'b0;
            cfg_reg.capacity    <= CNT_W'(64);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/fpsw_step.sv =====
// ---------------------------------------------------------------------------
// fpsw_step
// Single-pass logic for one item: bounds choice, frame checks, next state
// and result.
// ---------------------------------------------------------------------------
module fpsw_step
    import fpsw_pkg::*;
#(
    parameter int PAGE_BITS = 12,
    parameter int MAX_DEPTH = 64
)
(
    input  cfg_t              cfg,
    input  walk_state_t       state,
    input  logic              func,
    input  logic [ADDR_W-1:0] start_ip,
    input  logic [ADDR_W-1:0] start_fp,
    input  logic [ADDR_W-1:0] start_sp,
    input  logic [ADDR_W-1:0] saved_link,
    input  logic [ADDR_W-1:0] saved_return,
    output logic              emit,
    output result_t           result,
    output walk_state_t       state_next
);

    localparam logic [ADDR_W-1:0] PAGE_BYTES = 64'd1 << PAGE_BITS;
    localparam logic [ADDR_W-1:0] PAGE_MASK  = ~(PAGE_BYTES - 64'd1);
    localparam logic [ADDR_W-1:0] LINK_SPAN  = 64'd2 << PAGE_BITS;
    localparam logic [CNT_W-1:0]  DEPTH_MAX  = CNT_W'(MAX_DEPTH);

    logic [CNT_W-1:0]  cap_lim;
    logic              use_kstack;
    logic [ADDR_W-1:0] page_lo;
    logic [ADDR_W-1:0] page_lim;
    logic [ADDR_W-1:0] kstack_lim;
    logic              ok_kstack;
    logic              ok_page;
    logic              ip_canon;
    logic [CNT_W-1:0]  start_col;
    logic              ret_canon;
    logic [CNT_W-1:0]  col_inc;
    logic [ADDR_W-1:0] link_diff;
    logic              link_bad;
    logic              link_ok;

    always_comb
    begin
        cap_lim = cfg.capacity;
        if (cap_lim == '0)
            cap_lim = CNT_W'(1);
        if (cap_lim > DEPTH_MAX)
            cap_lim = DEPTH_MAX;
    end

    assign use_kstack = cfg.stack_known && (cfg.stack_base != '0) &&
                        (start_sp >= cfg.stack_base) && (start_sp < cfg.stack_top);
    assign page_lo    = start_sp & PAGE_MASK;
    assign page_lim   = page_lo + PAGE_BYTES - FRAME_SPAN;
    assign kstack_lim = cfg.stack_top - FRAME_SPAN;
    assign ok_kstack  = frame_ok(start_fp, cfg.stack_base, kstack_lim);
    assign ok_page    = frame_ok(start_fp, page_lo, page_lim);
    assign ip_canon   = is_canonical(start_ip);
    assign start_col  = ip_canon ? CNT_W'(1) : CNT_W'(0);

    assign ret_canon  = is_canonical(saved_return);
    assign col_inc    = state.collected + CNT_W'(1);
    assign link_diff  = saved_link - state.current_frame;
    assign link_bad   = (saved_link <= state.current_frame) || (link_diff > LINK_SPAN);
    assign link_ok    = frame_ok(saved_link, state.lower_bound, state.upper_limit);

    always_comb
    begin
        state_next = state;
        result     = '0;
        emit       = 1'b0;
        if (!func)
        begin
            emit                     = 1'b1;
            state_next.lower_bound   = use_kstack ? cfg.stack_base : page_lo;
            state_next.upper_limit   = use_kstack ? kstack_lim : page_lim;
            state_next.current_frame = start_fp;
            state_next.collected     = start_col;
            result.frame_valid       = ip_canon;
            result.frame_addr        = ip_canon ? start_ip : '0;
            if ((start_col < cap_lim) && (use_kstack ? ok_kstack : ok_page))
            begin
                result.fetch_valid  = 1'b1;
                result.fetch_addr   = start_fp;
                state_next.walking  = 1'b1;
            end
            else
            begin
                result.done_res     = 1'b1;
                state_next.walking  = 1'b0;
            end
            result.total_frames = start_col;
        end
        else if (state.walking)
        begin
            emit = 1'b1;
            if (!ret_canon)
            begin
                result.done_res    = 1'b1;
                state_next.walking = 1'b0;
            end
            else
            begin
                result.frame_valid   = 1'b1;
                result.frame_addr    = saved_return;
                result.frame_index   = state.collected[IDX_W-1:0];
                state_next.collected = col_inc;
                if (link_bad)
                begin
                    result.done_res    = 1'b1;
                    state_next.walking = 1'b0;
                end
                else
                begin
                    state_next.current_frame = saved_link;
                    if ((col_inc < cap_lim) && link_ok)
                    begin
                        result.fetch_valid = 1'b1;
                        result.fetch_addr  = saved_link;
                        state_next.walking = 1'b1;
                    end
                    else
                    begin
                        result.done_res    = 1'b1;
                        state_next.walking = 1'b0;
                    end
                end
            end
            result.total_frames = state_next.collected;
        end
    end

endmodule
